[src/ssf_pkg.sv]
// Shared types and constants of the separation steering force block.
// Used by ssf_ctrl, ssf_datapath and separation_steering_force_top; depends on nothing.
`default_nettype none
package ssf_pkg;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 48;
   localparam int unsigned SQ_STEPS   = 4;
   localparam int unsigned CNT_W      = 6;

   localparam logic [2:0] REG_DESIRED_SEP = 3'd0;
   localparam logic [2:0] REG_MIN_DIST    = 3'd1;
   localparam logic [2:0] REG_MAX_DIST    = 3'd2;
   localparam logic [2:0] REG_FAR_DIST    = 3'd3;
   localparam logic [2:0] REG_SCALE_X     = 3'd4;
   localparam logic [2:0] REG_SCALE_Y     = 3'd5;
   localparam logic [2:0] REG_SCALE_Z     = 3'd6;

   localparam logic [31:0] RST_DESIRED_SEP = 32'd1638400;
   localparam logic [31:0] RST_MIN_DIST    = 32'd65536;
   localparam logic [31:0] RST_MAX_DIST    = 32'd6553600;
   localparam logic [31:0] RST_FAR_DIST    = 32'd655360000;
   localparam logic [31:0] RST_SCALE       = 32'd65536;

   typedef struct packed {
      logic signed [31:0] self_x;
      logic signed [31:0] self_y;
      logic signed [31:0] self_z;
      logic signed [31:0] other_x;
      logic signed [31:0] other_y;
      logic signed [31:0] other_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_CHECK,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_ACC,
      OP_NORM_INIT,
      OP_SHIFT_R,
      OP_SHIFT_L,
      OP_SCALE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic counted;
      logic mx_zero;
      logic mx_high;
      logic mx_low;
   } sts_type;

endpackage
`default_nettype wire

[src/ssf_datapath.sv]
// Datapath: configuration registers, accumulators, shared multiplier,
// bit-serial square root and three divider lanes. Depends on ssf_pkg.
`default_nettype none
module ssf_datapath
   import ssf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire req_type     req_data,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output rsp_type          rsp_data
);

   localparam logic [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
   localparam logic [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

   logic [31:0] desired_ff, min_ff, max_ff, far_ff;
   logic [31:0] scale_ff [3];

   logic signed [32:0] d_ff [3], d_in [3];
   logic signed [31:0] vel_ff [3], vel_in [3];
   logic               last_ff, last_in;
   logic signed [47:0] sum_ff [3], sum_in [3];
   logic [47:0]        m_ff [3], m_in [3];
   logic [47:0]        mx_ff, mx_in;
   logic               zero_ff, zero_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [64:0]        s_ff, s_in;
   logic               ign_ff, ign_in;
   logic [63:0]        rad_ff, rad_in;
   logic [33:0]        srem_ff, srem_in;
   logic [31:0]        root_ff, root_in;
   logic [31:0]        divisor_ff, divisor_in;
   logic [47:0]        dvd_ff [3], dvd_in [3];
   logic [31:0]        drem_ff [3], drem_in [3];
   logic signed [31:0] force_ff [3], force_in [3];

   logic [32:0]        ad [3];
   logic signed [18:0] nvec [3];
   logic signed [32:0] mul_a, mul_b;
   logic [31:0]        sq_opnd;
   logic               counted;
   logic [31:0]        clamp_div;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ad[k] = d_ff[k][32] ? 33'(-d_ff[k]) : 33'(d_ff[k]);
         nvec[k] = zero_ff ? 19'sd0 :
                   (sum_ff[k][47] ? -$signed({1'b0, dvd_ff[k][17:0]})
                                  :  $signed({1'b0, dvd_ff[k][17:0]}));
      end
      counted = !ign_ff && (s_ff != 65'd0) && (root_ff < desired_ff);
      if (root_ff < min_ff) clamp_div = min_ff;
      else if (root_ff > max_ff) clamp_div = far_ff;
      else clamp_div = root_ff;
      if (clamp_div == 32'd0) clamp_div = 32'd1;
   end

   // Operand select for the shared multiplier.
   always_comb begin
      case (cmd.idx)
         2'd0: sq_opnd = cmd.fin ? m_ff[0][31:0] : ad[0][31:0];
         2'd1: sq_opnd = cmd.fin ? m_ff[1][31:0] : ad[1][31:0];
         2'd2: sq_opnd = cmd.fin ? m_ff[2][31:0] : ad[2][31:0];
         default: sq_opnd = 32'd0;
      endcase
      if (cmd.op == OP_SCALE) begin
         case (cmd.idx)
            2'd0: begin mul_a = 33'(nvec[0]); mul_b = 33'($signed(scale_ff[0])); end
            2'd1: begin mul_a = 33'(nvec[1]); mul_b = 33'($signed(scale_ff[1])); end
            2'd2: begin mul_a = 33'(nvec[2]); mul_b = 33'($signed(scale_ff[2])); end
            default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
         endcase
      end else begin
         mul_a = $signed({1'b0, sq_opnd});
         mul_b = $signed({1'b0, sq_opnd});
      end
   end

   always_comb begin
      logic [35:0]        rsh, trial;
      logic [32:0]        dsh;
      logic [47:0]        qc;
      logic signed [48:0] term;
      logic signed [49:0] acc;
      logic signed [50:0] fdiff;
      logic [1:0]         j;
      logic               ge;
      for (int k = 0; k < 3; k++) begin
         d_in[k] = d_ff[k]; vel_in[k] = vel_ff[k]; sum_in[k] = sum_ff[k];
         m_in[k] = m_ff[k]; dvd_in[k] = dvd_ff[k]; drem_in[k] = drem_ff[k];
         force_in[k] = force_ff[k];
      end
      last_in = last_ff; mx_in = mx_ff; zero_in = zero_ff; prod_in = prod_ff;
      s_in = s_ff; ign_in = ign_ff; rad_in = rad_ff; srem_in = srem_ff;
      root_in = root_ff; divisor_in = divisor_ff;
      rsh = '0; trial = '0; dsh = '0; qc = '0; term = '0; acc = '0; fdiff = '0;
      j = 2'd0; ge = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            d_in[0] = 33'(req_data.self_x) - 33'(req_data.other_x);
            d_in[1] = 33'(req_data.self_y) - 33'(req_data.other_y);
            d_in[2] = 33'(req_data.self_z) - 33'(req_data.other_z);
            vel_in[0] = req_data.vel_x;
            vel_in[1] = req_data.vel_y;
            vel_in[2] = req_data.vel_z;
            last_in = req_data.last;
         end
         OP_SQ: begin
            // Products are one step ahead of the running sum.
            if (cmd.idx != 2'd3) begin
               prod_in = mul_a * mul_b;
               if (!cmd.fin && ad[cmd.idx][32]) ign_in = 1'b1;
            end
            if (cmd.idx == 2'd0) begin
               s_in = 65'd0;
               ign_in = !cmd.fin && ad[0][32];
            end else begin
               s_in = {1'b0, s_ff[63:0]} + {1'b0, prod_ff[63:0]};
               if (s_in[64]) ign_in = 1'b1;
            end
         end
         OP_SQRT_INIT: begin
            rad_in = s_ff[63:0]; srem_in = '0; root_in = '0;
         end
         OP_SQRT_STEP: begin
            rsh = {srem_ff, rad_ff[63:62]};
            trial = {2'b00, root_ff, 2'b01};
            ge = rsh >= trial;
            srem_in = ge ? 34'(rsh - trial) : rsh[33:0];
            root_in = {root_ff[30:0], ge};
            rad_in = {rad_ff[61:0], 2'b00};
         end
         OP_CHECK: divisor_in = clamp_div;
         OP_DIV_INIT: begin
            if (cmd.fin) divisor_in = root_ff;
            for (int k = 0; k < 3; k++) begin
               dvd_in[k] = cmd.fin ? {m_ff[k][31:0], 16'd0} : {ad[k][31:0], 16'd0};
               drem_in[k] = '0;
            end
         end
         OP_DIV_STEP: begin
            for (int k = 0; k < 3; k++) begin
               dsh = {drem_ff[k], dvd_ff[k][47]};
               ge = dsh >= {1'b0, divisor_ff};
               drem_in[k] = ge ? 32'(dsh - {1'b0, divisor_ff}) : dsh[31:0];
               dvd_in[k] = {dvd_ff[k][46:0], ge};
            end
         end
         OP_ACC: begin
            for (int k = 0; k < 3; k++) begin
               qc = dvd_ff[k][47] ? SUM_MIN : dvd_ff[k];
               if (d_ff[k][32]) term = -$signed({1'b0, qc});
               else term = $signed({1'b0, dvd_ff[k][47] ? SUM_MAX : dvd_ff[k]});
               acc = 50'(sum_ff[k]) + 50'(term);
               if (acc > 50'($signed(SUM_MAX))) sum_in[k] = $signed(SUM_MAX);
               else if (acc < 50'($signed(SUM_MIN))) sum_in[k] = $signed(SUM_MIN);
               else sum_in[k] = acc[47:0];
            end
         end
         OP_NORM_INIT: begin
            for (int k = 0; k < 3; k++)
               m_in[k] = sum_ff[k][47] ? 48'(-sum_ff[k]) : 48'(sum_ff[k]);
            mx_in = m_in[0];
            if (m_in[1] > mx_in) mx_in = m_in[1];
            if (m_in[2] > mx_in) mx_in = m_in[2];
            zero_in = mx_in == 48'd0;
         end
         OP_SHIFT_R: begin
            for (int k = 0; k < 3; k++) m_in[k] = m_ff[k] >> 1;
            mx_in = mx_ff >> 1;
         end
         OP_SHIFT_L: begin
            for (int k = 0; k < 3; k++) m_in[k] = m_ff[k] << 1;
            mx_in = mx_ff << 1;
         end
         OP_SCALE: begin
            if (cmd.idx != 2'd3) prod_in = mul_a * mul_b;
            if (cmd.idx != 2'd0) begin
               j = cmd.idx - 2'd1;
               fdiff = 51'(prod_ff >>> 16) - 51'(vel_ff[j]);
               if (fdiff > 51'sh7FFFFFFF) force_in[j] = 32'sh7FFFFFFF;
               else if (fdiff < -51'sh80000000) force_in[j] = -32'sh80000000;
               else force_in[j] = fdiff[31:0];
            end
            if (cmd.idx == 2'd3)
               for (int k = 0; k < 3; k++) sum_in[k] = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desired_ff <= RST_DESIRED_SEP;
         min_ff     <= RST_MIN_DIST;
         max_ff     <= RST_MAX_DIST;
         far_ff     <= RST_FAR_DIST;
         for (int k = 0; k < 3; k++) begin
            scale_ff[k] <= RST_SCALE;
            sum_ff[k]   <= '0;
         end
      end else begin
         for (int k = 0; k < 3; k++) sum_ff[k] <= sum_in[k];
         if (csr_we) begin
            case (csr_index)
               REG_DESIRED_SEP: desired_ff  <= csr_wdata;
               REG_MIN_DIST:    min_ff      <= csr_wdata;
               REG_MAX_DIST:    max_ff      <= csr_wdata;
               REG_FAR_DIST:    far_ff      <= csr_wdata;
               REG_SCALE_X:     scale_ff[0] <= csr_wdata;
               REG_SCALE_Y:     scale_ff[1] <= csr_wdata;
               REG_SCALE_Z:     scale_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         d_ff[k] <= d_in[k]; vel_ff[k] <= vel_in[k]; m_ff[k] <= m_in[k];
         dvd_ff[k] <= dvd_in[k]; drem_ff[k] <= drem_in[k]; force_ff[k] <= force_in[k];
      end
      last_ff <= last_in; mx_ff <= mx_in; zero_ff <= zero_in; prod_ff <= prod_in;
      s_ff <= s_in; ign_ff <= ign_in; rad_ff <= rad_in; srem_ff <= srem_in;
      root_ff <= root_in; divisor_ff <= divisor_in;
   end

   assign sts.last    = last_ff;
   assign sts.counted = counted;
   assign sts.mx_zero = zero_ff;
   assign sts.mx_high = mx_ff[47:31] != 17'd0;
   assign sts.mx_low  = mx_ff[47:30] == 18'd0;

   assign rsp_data.force_x = force_ff[0];
   assign rsp_data.force_y = force_ff[1];
   assign rsp_data.force_z = force_ff[2];

endmodule
`default_nettype wire

[src/ssf_ctrl.sv]
// Sequencer that steps the datapath through one item and owns both handshakes.
// Depends on ssf_pkg.
`default_nettype none
module ssf_ctrl
   import ssf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   input  wire sts_type sts,
   output cmd_type   cmd
);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_SQ     = 12'b000000000010,
      S_SQRTI  = 12'b000000000100,
      S_SQRT   = 12'b000000001000,
      S_CHECK  = 12'b000000010000,
      S_DIVI   = 12'b000000100000,
      S_DIV    = 12'b000001000000,
      S_ACC    = 12'b000010000000,
      S_NINIT  = 12'b000100000000,
      S_NSHIFT = 12'b001000000000,
      S_WAIT   = 12'b010000000000,
      S_SCALE  = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               fin_ff, fin_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op = OP_NONE;
      cmd.idx = cnt_ff[1:0];
      cmd.fin = fin_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = S_SQ;
               cnt_in = '0;
               fin_in = 1'b0;
            end
         end
         S_SQ: begin
            cmd.op = OP_SQ;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQ_STEPS - 1)) state_in = S_SQRTI;
         end
         S_SQRTI: begin
            cmd.op = OP_SQRT_INIT;
            cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = fin_ff ? S_DIVI : S_CHECK;
         end
         S_CHECK: begin
            cmd.op = OP_CHECK;
            if (sts.counted) state_in = S_DIVI;
            else state_in = sts.last ? S_NINIT : S_IDLE;
         end
         S_DIVI: begin
            cmd.op = OP_DIV_INIT;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = fin_ff ? S_WAIT : S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            state_in = sts.last ? S_NINIT : S_IDLE;
         end
         S_NINIT: begin
            cmd.op = OP_NORM_INIT;
            state_in = S_NSHIFT;
         end
         S_NSHIFT: begin
            if (sts.mx_zero) state_in = S_WAIT;
            else if (sts.mx_high) cmd.op = OP_SHIFT_R;
            else if (sts.mx_low) cmd.op = OP_SHIFT_L;
            else begin
               state_in = S_SQ;
               cnt_in = '0;
               fin_in = 1'b1;
            end
         end
         S_WAIT: begin
            if (!rsp_valid_ff) begin
               state_in = S_SCALE;
               cnt_in = '0;
            end
         end
         S_SCALE: begin
            cmd.op = OP_SCALE;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQ_STEPS - 1)) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               fin_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         fin_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCALE) |-> !rsp_valid_ff)
      else $error("result register written while a beat is pending");
   a_sqrt_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (cnt_ff < CNT_W'(SQRT_STEPS)))
      else $error("square root ran past its step count");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider ran past its step count");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SQ && !fin_ff && cnt_ff == '0))
      else $error("accepted beat did not start a neighbor pass");

endmodule
`default_nettype wire

[src/separation_steering_force_top.sv]
// Top level of the separation steering force block: controller plus datapath.
// Depends on ssf_pkg, ssf_ctrl and ssf_datapath.
//
// Usage: each req beat carries the particle position, one neighbor position
// and, on the beat with last set, the particle velocity. Beats are taken one at
// a time: req_ready is high only while the sequencer is idle. The cost of a
// neighbor beat is set by the one-bit-per-cycle square root (32 steps) and,
// when it counts, by the 48-step divider whose three axis lanes share one
// divisor. A last beat adds the normalization: shifts of the sums, a second
// square root and division and the scaling, after which one rsp beat with
// the saturated force appears.
// The result sits in an output register, so a stalled receiver does not stop
// the next run from being accumulated; only the final scaling of a later run
// waits until the pending rsp beat has been taken.
// Configuration writes on the csr port are registered and must be made
// while the block is idle. A synchronous reset restores the default register
// values, clears the accumulated sums and drops any pending result.
`default_nettype none
module separation_steering_force_top
   import ssf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // The sequencer issues one datapath command per cycle and branches on status.
   ssf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the registers, sums and arithmetic units.
   ssf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking bench for separation_steering_force_top: random and directed neighbor runs.
// Depends on ssf_pkg and the block's RTL only; an internal scoreboard predicts every force.
`default_nettype none
module tb;
   import ssf_pkg::*;

   // Index that no register decodes; a write to it must change nothing.
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam longint     SUM_HI     = 64'sh7FFF_FFFF_FFFF;
   localparam longint     SUM_LO     = -SUM_HI - 1;
   localparam int         WATCHDOG   = 20000;
   localparam int         DRAIN      = 300;
   localparam int         HOLD_LEN   = 2000;

   // Predicts the steering force from the accepted neighbor beats and compares the results.
   class force_scoreboard;
      logic [31:0]      cfg [7];
      longint           acc [3];
      rsp_type          pending [$];
      int               errors;

      function new();
         cfg[REG_DESIRED_SEP] = RST_DESIRED_SEP;
         cfg[REG_MIN_DIST]    = RST_MIN_DIST;
         cfg[REG_MAX_DIST]    = RST_MAX_DIST;
         cfg[REG_FAR_DIST]    = RST_FAR_DIST;
         cfg[REG_SCALE_X]     = RST_SCALE;
         cfg[REG_SCALE_Y]     = RST_SCALE;
         cfg[REG_SCALE_Z]     = RST_SCALE;
         foreach (acc[i]) acc[i] = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         if (idx <= REG_SCALE_Z) cfg[idx] = val;
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned res, bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v   = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function longint unsigned mag(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      function longint clip48(longint v);
         if (v > SUM_HI) return SUM_HI;
         if (v < SUM_LO) return SUM_LO;
         return v;
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Adds one neighbor's weighted offset to the running sums.
      function void absorb(longint d [3]);
         longint unsigned a, sq, s, span, div, q;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            a = mag(d[i]);
            if (a > 64'hFFFF_FFFF) return;
            sq = a * a;
            if (s > ~64'd0 - sq) return;
            s = s + sq;
         end
         if (s == 0) return;
         span = root(s);
         if (!(span < cfg[REG_DESIRED_SEP])) return;
         if (span < cfg[REG_MIN_DIST]) div = cfg[REG_MIN_DIST];
         else if (span > cfg[REG_MAX_DIST]) div = cfg[REG_FAR_DIST];
         else div = span;
         if (div == 0) div = 1;
         for (int i = 0; i < 3; i++) begin
            q = (mag(d[i]) << 16) / div;
            if (q > SUM_HI) q = SUM_HI + 1;
            acc[i] = clip48(acc[i] + clip48(d[i] < 0 ? -longint'(q) : longint'(q)));
         end
      endfunction

      // Notes an accepted req beat and queues the force it produces, if any.
      function void note_beat(req_type r);
         longint          d [3];
         longint unsigned m [3];
         longint unsigned mx, len;
         longint          unit [3];
         longint          vel [3];
         longint          f [3];
         rsp_type         e;
         d[0] = longint'(r.self_x) - longint'(r.other_x);
         d[1] = longint'(r.self_y) - longint'(r.other_y);
         d[2] = longint'(r.self_z) - longint'(r.other_z);
         absorb(d);
         if (!r.last) return;
         for (int i = 0; i < 3; i++) begin
            m[i]    = mag(acc[i]);
            unit[i] = 0;
         end
         mx = m[0];
         if (m[1] > mx) mx = m[1];
         if (m[2] > mx) mx = m[2];
         if (mx != 0) begin
            while (mx >= (64'd1 << 31)) begin
               mx = mx >> 1;
               for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < (64'd1 << 30)) begin
               mx = mx << 1;
               for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            len = root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int i = 0; i < 3; i++) begin
               unit[i] = longint'((m[i] << 16) / len);
               if (acc[i] < 0) unit[i] = -unit[i];
            end
         end
         vel[0] = longint'(r.vel_x);
         vel[1] = longint'(r.vel_y);
         vel[2] = longint'(r.vel_z);
         for (int i = 0; i < 3; i++)
            f[i] = clip32(((unit[i] * longint'($signed(cfg[REG_SCALE_X + i]))) >>> 16)
                          - vel[i]);
         e.force_x = f[0][31:0];
         e.force_y = f[1][31:0];
         e.force_z = f[2][31:0];
         pending.push_back(e);
         foreach (acc[i]) acc[i] = 0;
      endfunction

      task report(string msg);
         $display("tb mismatch: %s", msg);
         errors++;
      endtask

      task check_beat(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report("rsp beat with no force expected");
            return;
         end
         e = pending.pop_front();
         if (got.force_x !== e.force_x)
            report($sformatf("force_x got %h want %h", got.force_x, e.force_x));
         if (got.force_y !== e.force_y)
            report($sformatf("force_y got %h want %h", got.force_y, e.force_y));
         if (got.force_z !== e.force_z)
            report($sformatf("force_z got %h want %h", got.force_z, e.force_z));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   force_scoreboard sb;
   req_type         beats [$];
   int              tx_idle_pct;
   int              rx_idle_pct;
   int              hold_left;
   int              quiet_cycles;

   separation_steering_force_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver takes rsp beats, idles at the current rate, and during a hold-off
   // keeps rsp_ready low so that the block fills up and stops taking req beats.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_beat(rsp_data);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // The watchdog ends a run in which no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Writes a full register set in back-to-back cycles, plus one write to an
   // undecoded index that must leave every register untouched.
   task write_regs(logic [31:0] vals [7]);
      for (int i = 0; i <= REG_SCALE_Z; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= vals[i];
         sb.write_reg(i[2:0], vals[i]);
         @(posedge clock);
      end
      csr_index <= REG_UNUSED;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drives every queued req beat, with random gaps at the current idle rate.
   // Valid is lowered only when a gap follows, so it never toggles within one step.
   task send_beats();
      req_type r;
      int      gap;
      while (beats.size() > 0) begin
         r = beats.pop_front();
         if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= r;
         do @(posedge clock); while (!req_ready);
         sb.note_beat(r);
      end
      req_valid <= 1'b0;
   endtask

   // Waits until every expected force has arrived and the block has gone idle.
   task settle();
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function req_type near_beat(logic last);
      req_type r;
      int      reach;
      r = '0;
      reach = (1 << 16) << $urandom_range(0, 9);
      r.self_x  = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 1 << 24));
      r.self_y  = $urandom;
      r.self_z  = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      r.other_x = r.self_x + $signed($urandom_range(0, 2 * reach)) - reach;
      r.other_y = r.self_y + $signed($urandom_range(0, 2 * reach)) - reach;
      r.other_z = r.self_z + $signed($urandom_range(0, 2 * reach)) - reach;
      if ($urandom_range(0, 9) == 0) begin
         r.other_x = $urandom;
         r.other_y = $urandom;
         r.other_z = $urandom;
      end
      if ($urandom_range(0, 15) == 0) r.other_y = r.self_y;
      if ($urandom_range(0, 1) == 0) begin
         r.vel_x = $urandom;
         r.vel_y = $urandom;
         r.vel_z = $urandom;
      end else begin
         r.vel_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         r.vel_y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         r.vel_z = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      end
      r.last = last;
      return r;
   endfunction

   // Queues complete neighbor runs with random content, and now and then a stray beat.
   task queue_runs(int count);
      int len;
      while (count > 0) begin
         len = $urandom_range(1, 8);
         for (int k = 1; k <= len; k++)
            beats.push_back(near_beat(k == len || $urandom_range(0, 40) == 0));
         count -= len;
      end
   endtask

   task queue_directed();
      req_type r;
      // Neighbor at the particle itself: zero distance never counts; the force is
      // minus the velocity, with a velocity of the most negative value.
      r = '0;
      r.self_x = 32'sh0001_0000; r.other_x = 32'sh0001_0000;
      r.vel_x = 32'sh8000_0000; r.vel_y = 32'sh7FFF_FFFF; r.vel_z = -1;
      r.last = 1'b1;
      beats.push_back(r);
      // Positions at opposite extremes: a huge separation is ignored.
      r = '0;
      r.self_x = 32'sh7FFF_FFFF; r.self_y = 32'sh7FFF_FFFF; r.self_z = 32'sh7FFF_FFFF;
      r.other_x = 32'sh8000_0000; r.other_y = 32'sh8000_0000; r.other_z = 32'sh8000_0000;
      beats.push_back(r);
      r.other_y = 32'sh7FFF_FFFF; r.other_z = 32'sh7FFF_FFFF;
      r.last = 1'b1;
      beats.push_back(r);
      // Close neighbors: below the minimum clamp, in band, and one on each axis.
      r = '0;
      r.other_x = 32'sh0000_4000;
      beats.push_back(r);
      r.other_x = 0; r.other_y = -32'sh0005_0000;
      beats.push_back(r);
      r.other_y = 0; r.other_z = 32'sh0010_0000;
      r.vel_x = 32'sh0002_0000;
      r.last = 1'b1;
      beats.push_back(r);
      // Several neighbors that cancel on one axis and pile up on another.
      r = '0;
      r.other_x = 32'sh0003_0000; r.other_y = 32'sh0001_0000;
      beats.push_back(r);
      r.other_x = -32'sh0003_0000;
      beats.push_back(r);
      r.other_x = 0; r.other_y = 32'sh0000_0001;
      r.last = 1'b1;
      beats.push_back(r);
   endtask

   initial begin
      logic [31:0] regs [7];
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = REG_DESIRED_SEP;
      csr_wdata   = '0;
      tx_idle_pct = 7;
      rx_idle_pct = 87;
      hold_left   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: reset values, directed cases, then random runs.
      queue_directed();
      queue_runs(300);
      send_beats();
      settle();

      // Phase two: widest radius, no minimum clamp, a far distance of zero so the
      // divisor falls back to one LSB, and extreme gains.
      regs = '{32'hFFFF_FFFF, 32'd0, 32'h000A_0000, 32'd0,
               32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
      write_regs(regs);
      queue_directed();
      queue_runs(300);
      send_beats();
      settle();

      // The idle rates swap: the sender is slow and the receiver mostly ready.
      tx_idle_pct = 87;
      rx_idle_pct = 7;

      // Phase three: a zero radius, so no neighbor counts at all.
      regs = '{32'd0, 32'h0001_0000, 32'h0064_0000, 32'h2710_0000,
               $urandom, $urandom, $urandom};
      write_regs(regs);
      queue_runs(250);
      send_beats();
      settle();

      // Phase four: moderate band with mixed gains, and a long receiver hold-off
      // while the sender keeps offering beats.
      regs = '{32'h0032_0000, 32'h0005_0000, 32'h0014_0000, 32'h001E_0000,
               32'h0002_0000, 32'hFFFE_8000, 32'h0000_8000};
      write_regs(regs);
      hold_left = HOLD_LEN;
      tx_idle_pct = 0;
      queue_runs(300);
      send_beats();
      settle();

      // Neither side idles from here on.
      tx_idle_pct = 0;
      rx_idle_pct = 0;

      // Phase five: fully random registers, with a wide radius most of the time.
      regs = '{$urandom | 32'h0100_0000, $urandom_range(0, 1 << 18), $urandom,
               $urandom, $urandom, $urandom, $urandom};
      write_regs(regs);
      queue_runs(400);
      send_beats();
      settle();

      // Phase six: back to the reset values.
      regs = '{RST_DESIRED_SEP, RST_MIN_DIST, RST_MAX_DIST, RST_FAR_DIST,
               RST_SCALE, RST_SCALE, RST_SCALE};
      write_regs(regs);
      queue_runs(400);
      send_beats();
      settle();

      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
src/ssf_pkg.sv
src/ssf_datapath.sv
src/ssf_ctrl.sv
src/separation_steering_force_top.sv
test/tb.sv
